// File: src/r2dif_pkg.sv
// ----------------------------------------------------------------------------
// r2dif_pkg: shared types and constants of the radix-2 DIF transform
// Sizes, controller states, datapath command struct and the twiddle table.
// ----------------------------------------------------------------------------
package r2dif_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int MAX_LOG    = ADDR_W;
	localparam int LOG_W      = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int DATA_BITS  = 27;
	localparam int TW_FRAC    = 16;
	localparam int TW_W       = TW_FRAC + 2;
	localparam int TW_MAG_W   = TW_FRAC + 1;
	localparam int TW_IDX_W   = ADDR_W - 1;
	localparam int TW_DEPTH   = MAX_POINTS / 4 + 1;
	localparam int TW_ROM_W   = 2 * TW_MAG_W;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int TAYLOR_TERMS = 10;

	// register index on the configuration port
	localparam logic REG_LOG2_POINTS = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_ADD,
		ST_BF_WB,
		ST_FETCH
	} state_t;

	typedef enum logic [1:0] {
		WR_LOAD,
		WR_SUM,
		WR_PROD
	} wr_sel_t;

	typedef struct packed {
		logic              wr_en;
		wr_sel_t           wr_sel;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_a_addr;
		logic [ADDR_W-1:0] rd_b_addr;
		logic [TW_IDX_W-1:0] tw_idx;
		logic              out_load;
		logic              out_err;
		logic [ADDR_W-1:0] out_index;
		logic              out_last;
	} dp_cmd_t;

	typedef logic [TW_ROM_W-1:0] tw_rom_t [TW_DEPTH];

	// shift-and-subtract quotient, used only while building the table
	function automatic longint unsigned udiv(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = (r << 1) | ((num >> i) & 64'd1);
			if (r >= den) begin
				r = r - den;
				q = q | (64'd1 << i);
			end
		end
		return q;
	endfunction

	// cos/sin magnitude of angle 2*pi*u/MAX_POINTS, Q30 taylor series, rounded to Q1.16
	function automatic logic [TW_ROM_W-1:0] tw_entry(input int unsigned u);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ct;
		longint unsigned st;
		longint cacc;
		longint sacc;
		longint c_r;
		longint s_r;
		int k;
		x = (longint'(u) * (2 * PI_Q30)) >> ADDR_W;
		x2 = (x * x) >> 30;
		ct = 64'd1 << 30;
		st = x;
		cacc = longint'(ct);
		sacc = longint'(st);
		for (k = 1; k <= TAYLOR_TERMS; k++) begin
			ct = udiv((ct * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
			st = udiv((st * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
			if ((k & 1) == 1) begin
				cacc = cacc - longint'(ct);
				sacc = sacc - longint'(st);
			end else begin
				cacc = cacc + longint'(ct);
				sacc = sacc + longint'(st);
			end
		end
		if (cacc < 0) cacc = 0;
		if (sacc < 0) sacc = 0;
		c_r = (cacc + (longint'(1) << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);
		s_r = (sacc + (longint'(1) << (30 - TW_FRAC - 1))) >> (30 - TW_FRAC);
		return {c_r[TW_MAG_W-1:0], s_r[TW_MAG_W-1:0]};
	endfunction

	function automatic tw_rom_t build_tw_rom();
		tw_rom_t rom;
		for (int i = 0; i < TW_DEPTH; i++) begin
			rom[i] = tw_entry(i);
		end
		return rom;
	endfunction

	localparam tw_rom_t TW_ROM = build_tw_rom();

endpackage

// File: src/r2dif_dp.sv
// ----------------------------------------------------------------------------
// r2dif_dp: sample store, butterfly unit and result register
// Two-read one-write store, twiddle lookup, multiply and round/saturate stages.
// ----------------------------------------------------------------------------
module r2dif_dp (
	input  logic clk,
	input  logic arst_n,
	input  r2dif_pkg::dp_cmd_t cmd_in,
	input  logic signed [r2dif_pkg::SAMPLE_BITS-1:0] sample_re,
	input  logic signed [r2dif_pkg::SAMPLE_BITS-1:0] sample_im,
	output logic signed [r2dif_pkg::DATA_BITS-1:0] result_re,
	output logic signed [r2dif_pkg::DATA_BITS-1:0] result_im,
	output logic [r2dif_pkg::ADDR_W-1:0] result_index,
	output logic last,
	output logic status
);
	import r2dif_pkg::*;

	localparam int DIFF_W = DATA_BITS + 1;
	localparam int MUL_W  = DIFF_W + TW_W;
	localparam int ACC_W  = MUL_W + 1;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd1 <<< (DATA_BITS - 1));
	localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'sd1 <<< (TW_FRAC - 1));
	localparam logic [TW_IDX_W:0] HALF_TURN   = (TW_IDX_W + 1)'(MAX_POINTS / 2);
	localparam logic [TW_IDX_W:0] QUARTER     = (TW_IDX_W + 1)'(MAX_POINTS / 4);

	function automatic logic signed [DATA_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
		if (v > SAT_HI) return SAT_HI[DATA_BITS-1:0];
		if (v < SAT_LO) return SAT_LO[DATA_BITS-1:0];
		return v[DATA_BITS-1:0];
	endfunction

	logic signed [DATA_BITS-1:0] mem_re [MAX_POINTS];
	logic signed [DATA_BITS-1:0] mem_im [MAX_POINTS];

	logic signed [DATA_BITS-1:0] a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	logic signed [TW_W-1:0] tw_re_s1, tw_im_s1;
	logic signed [MUL_W-1:0] m_rr_s2, m_ii_s2, m_ri_s2, m_ir_s2;
	logic signed [DATA_BITS-1:0] sum_re_s2, sum_im_s2;
	logic signed [DATA_BITS-1:0] prod_re_s3, prod_im_s3;
	logic signed [DATA_BITS-1:0] wr_re, wr_im;
	logic signed [DIFF_W-1:0] d_re, d_im;
	logic signed [ACC_W-1:0] p_re, p_im;
	logic [TW_IDX_W:0] t_ext;
	logic [TW_IDX_W:0] u_idx;
	logic tw_neg;
	logic [TW_ROM_W-1:0] rom_word;
	logic signed [TW_W-1:0] cos_mag, sin_mag;

	// fold the angle into the first quadrant
	assign t_ext   = {1'b0, cmd_in.tw_idx};
	assign tw_neg  = t_ext > QUARTER;
	assign u_idx   = tw_neg ? (HALF_TURN - t_ext) : t_ext;
	assign rom_word = TW_ROM[u_idx[TW_IDX_W-1:0]];
	assign cos_mag = TW_W'({1'b0, rom_word[TW_ROM_W-1:TW_MAG_W]});
	assign sin_mag = TW_W'({1'b0, rom_word[TW_MAG_W-1:0]});

	always_comb begin
		unique case (cmd_in.wr_sel)
			WR_LOAD: begin
				wr_re = DATA_BITS'(sample_re);
				wr_im = DATA_BITS'(sample_im);
			end
			WR_SUM: begin
				wr_re = sum_re_s2;
				wr_im = sum_im_s2;
			end
			WR_PROD: begin
				wr_re = prod_re_s3;
				wr_im = prod_im_s3;
			end
			default: begin
				wr_re = sum_re_s2;
				wr_im = sum_im_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_in.wr_en) begin
			mem_re[cmd_in.wr_addr] <= wr_re;
			mem_im[cmd_in.wr_addr] <= wr_im;
		end
		a_re_s1 <= mem_re[cmd_in.rd_a_addr];
		a_im_s1 <= mem_im[cmd_in.rd_a_addr];
		b_re_s1 <= mem_re[cmd_in.rd_b_addr];
		b_im_s1 <= mem_im[cmd_in.rd_b_addr];
	end

	assign d_re = DIFF_W'(a_re_s1) - DIFF_W'(b_re_s1);
	assign d_im = DIFF_W'(a_im_s1) - DIFF_W'(b_im_s1);
	assign p_re = ACC_W'(m_rr_s2) - ACC_W'(m_ii_s2) + RND;
	assign p_im = ACC_W'(m_ri_s2) + ACC_W'(m_ir_s2) + RND;

	always_ff @(posedge clk) begin
		tw_re_s1  <= tw_neg ? -cos_mag : cos_mag;
		tw_im_s1  <= sin_mag;
		m_rr_s2   <= d_re * tw_re_s1;
		m_ii_s2   <= d_im * tw_im_s1;
		m_ri_s2   <= d_re * tw_im_s1;
		m_ir_s2   <= d_im * tw_re_s1;
		sum_re_s2 <= sat(ACC_W'(a_re_s1) + ACC_W'(b_re_s1));
		sum_im_s2 <= sat(ACC_W'(a_im_s1) + ACC_W'(b_im_s1));
		prod_re_s3 <= sat(p_re >>> TW_FRAC);
		prod_im_s3 <= sat(p_im >>> TW_FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_re    <= '0;
			result_im    <= '0;
			result_index <= '0;
			last         <= 1'b0;
			status       <= 1'b0;
		end else if (cmd_in.out_load) begin
			if (cmd_in.out_err) begin
				result_re    <= '0;
				result_im    <= '0;
				result_index <= '0;
				last         <= 1'b0;
				status       <= 1'b1;
			end else begin
				result_re    <= a_re_s1;
				result_im    <= a_im_s1;
				result_index <= cmd_in.out_index;
				last         <= cmd_in.out_last;
				status       <= 1'b0;
			end
		end
	end

endmodule

// File: src/r2dif_ctrl.sv
// ----------------------------------------------------------------------------
// r2dif_ctrl: frame sequencer of the transform
// Load and fetch counters, butterfly stage/index counters, result handshake.
// ----------------------------------------------------------------------------
module r2dif_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr,
	input  logic [r2dif_pkg::LOG_W-1:0] cfg_data,
	output logic [r2dif_pkg::LOG_W-1:0] log2_points,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	output logic out_valid,
	input  logic out_stall,
	output r2dif_pkg::dp_cmd_t dp_cmd
);
	import r2dif_pkg::*;

	state_t state_q, state_nxt;
	logic [LOG_W-1:0] log2_q;
	logic [ADDR_W-1:0] load_cnt_q, fetch_cnt_q;
	logic done_q;
	logic [LOG_W-1:0] stage_q;
	logic [ADDR_W-2:0] bf_q;
	logic out_valid_q;
	logic in_acc;
	logic [ADDR_W-1:0] n_mask, half_mask, pm, bf_ext, c_a, c_b;
	logic load_last, fetch_last, bf_last, fft_end;
	logic [LOG_W-1:0] cfg_clamped;

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign log2_points = log2_q;

	assign n_mask    = ADDR_W'((1 << log2_q) - 1);
	assign half_mask = n_mask >> 1;
	assign pm        = ADDR_W'((1 << stage_q) - 1);
	assign bf_ext    = ADDR_W'(bf_q);
	// butterfly index with a zero bit inserted at the span position
	assign c_a       = ((bf_ext >> stage_q) << (stage_q + 1)) | (bf_ext & pm);
	assign c_b       = c_a | (pm + ADDR_W'(1));
	assign load_last  = load_cnt_q == n_mask;
	assign fetch_last = fetch_cnt_q == n_mask;
	assign bf_last    = bf_ext == half_mask;
	assign fft_end    = bf_last && (stage_q == '0);

	always_comb begin
		if (cfg_data == '0) cfg_clamped = LOG_W'(1);
		else if (cfg_data > LOG_W'(MAX_LOG)) cfg_clamped = LOG_W'(MAX_LOG);
		else cfg_clamped = cfg_data;
	end

	always_comb begin
		state_nxt         = state_q;
		dp_cmd            = '0;
		dp_cmd.wr_sel     = WR_LOAD;
		dp_cmd.rd_a_addr  = c_a;
		dp_cmd.rd_b_addr  = c_b;
		dp_cmd.tw_idx     = TW_IDX_W'((bf_ext & pm) << (TW_IDX_W - stage_q));
		dp_cmd.out_index  = fetch_cnt_q;
		dp_cmd.out_last   = fetch_last;
		unique case (state_q)
			ST_IDLE: begin
				dp_cmd.rd_a_addr = fetch_cnt_q;
				if (in_acc) begin
					if (!cmd) begin
						dp_cmd.wr_en   = 1'b1;
						dp_cmd.wr_addr = load_cnt_q;
						if (load_last) state_nxt = ST_BF_RD;
					end else if (done_q) begin
						state_nxt = ST_FETCH;
					end else begin
						dp_cmd.out_load = 1'b1;
						dp_cmd.out_err  = 1'b1;
					end
				end
			end
			ST_BF_RD:  state_nxt = ST_BF_MUL;
			ST_BF_MUL: state_nxt = ST_BF_ADD;
			ST_BF_ADD: begin
				dp_cmd.wr_en   = 1'b1;
				dp_cmd.wr_sel  = WR_SUM;
				dp_cmd.wr_addr = c_a;
				state_nxt      = ST_BF_WB;
			end
			ST_BF_WB: begin
				dp_cmd.wr_en   = 1'b1;
				dp_cmd.wr_sel  = WR_PROD;
				dp_cmd.wr_addr = c_b;
				state_nxt      = fft_end ? ST_IDLE : ST_BF_RD;
			end
			ST_FETCH: begin
				dp_cmd.rd_a_addr = fetch_cnt_q;
				dp_cmd.out_load  = 1'b1;
				state_nxt        = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q      <= LOG_W'(MAX_LOG);
			load_cnt_q  <= '0;
			fetch_cnt_q <= '0;
			done_q      <= 1'b0;
			stage_q     <= '0;
			bf_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;

			if (cfg_wr) begin
				log2_q      <= cfg_clamped;
				load_cnt_q  <= '0;
				fetch_cnt_q <= '0;
				done_q      <= 1'b0;
			end else begin
				if (state_q == ST_IDLE && in_acc && !cmd) begin
					done_q <= 1'b0;
					if (load_last) begin
						load_cnt_q <= '0;
						stage_q    <= log2_q - LOG_W'(1);
						bf_q       <= '0;
					end else begin
						load_cnt_q <= load_cnt_q + ADDR_W'(1);
					end
				end
				if (state_q == ST_BF_WB) begin
					if (bf_last) begin
						bf_q <= '0;
						if (stage_q == '0) begin
							done_q      <= 1'b1;
							fetch_cnt_q <= '0;
						end else begin
							stage_q <= stage_q - LOG_W'(1);
						end
					end else begin
						bf_q <= bf_q + (ADDR_W-1)'(1);
					end
				end
				if (state_q == ST_FETCH) begin
					if (fetch_last) begin
						fetch_cnt_q <= '0;
						done_q      <= 1'b0;
					end else begin
						fetch_cnt_q <= fetch_cnt_q + ADDR_W'(1);
					end
				end
			end
		end
	end

	a_no_result_in_fft: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BF_RD || state_q == ST_BF_MUL || state_q == ST_BF_ADD
		|| state_q == ST_BF_WB) |-> !out_valid_q)
		else $error("result pending during transform");

	a_fetch_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |=> out_valid_q)
		else $error("fetch did not load the result register");

	a_cfg_aborts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (load_cnt_q == '0 && fetch_cnt_q == '0 && !done_q))
		else $error("configuration write did not abort the frame");

endmodule

// File: src/radix2_dif_fft.sv
// ----------------------------------------------------------------------------
// radix2_dif_fft: in-place radix-2 decimation-in-frequency transform
// Load/fetch item channel, result channel and register port around the core.
// ----------------------------------------------------------------------------
// Load items (cmd 0) are taken one per cycle until the frame of
// N = 2^log2_points samples is complete. The last load starts the transform,
// which runs on one shared butterfly unit over a store with a single write
// port: each butterfly steps through read, multiply, write sum and write
// product; no item is taken during the transform. A fetch (cmd 1) passes
// through the fetch state to the result register; a fetch with no finished
// transform loads status 1 straight into the result register. Items are
// held off while a result waits to be taken, so no new item is taken before
// the last result has left. Results come in storage order, which is
// bit-reversed frequency order; last marks the final one.
module radix2_dif_fft (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic cmd,
	input  logic signed [r2dif_pkg::SAMPLE_BITS-1:0] sample_re,
	input  logic signed [r2dif_pkg::SAMPLE_BITS-1:0] sample_im,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [r2dif_pkg::DATA_BITS-1:0] result_re,
	output logic signed [r2dif_pkg::DATA_BITS-1:0] result_im,
	output logic [r2dif_pkg::ADDR_W-1:0] result_index,
	output logic last,
	output logic status,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import r2dif_pkg::*;

	dp_cmd_t dp_cmd;
	logic cfg_wr;
	logic [LOG_W-1:0] log2_points;
	logic reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == REG_LOG2_POINTS;
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? 32'(log2_points) : 32'd0;

	r2dif_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.cfg_data   (pwdata[LOG_W-1:0]),
		.log2_points(log2_points),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dp_cmd     (dp_cmd)
	);

	r2dif_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_in      (dp_cmd),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.result_re   (result_re),
		.result_im   (result_im),
		.result_index(result_index),
		.last        (last),
		.status      (status)
	);

endmodule
